@@ rtl/bca_pkg.sv @@
// bca_pkg: constants, codes and control structs of the bitmap chunk allocator
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package bca_pkg;

	localparam int NUM_CHUNKS   = 8192;
	localparam int CHUNK_BYTES  = 128;
	localparam int HEADER_BYTES = 16;
	localparam int WORD_BITS    = 64;
	localparam int NUM_WORDS    = NUM_CHUNKS / WORD_BITS;
	localparam int WORD_SHIFT   = $clog2(WORD_BITS);
	localparam int WORD_AW      = $clog2(NUM_WORDS);
	localparam int CHUNK_AW     = $clog2(NUM_CHUNKS);
	localparam int CHUNK_SHIFT  = $clog2(CHUNK_BYTES);
	localparam int COUNT_W      = 14;
	localparam int BYTES_W      = 21;
	localparam int NEED_W       = 15;
	localparam int RUN_W        = 16;

	// request kinds
	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_BAD    = 2'd3;

	// result status
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

	// datapath commands
	localparam logic [4:0] CMD_NOP          = 5'd0;
	localparam logic [4:0] CMD_CLEAR        = 5'd1;
	localparam logic [4:0] CMD_LOAD         = 5'd2;
	localparam logic [4:0] CMD_LEN          = 5'd3;
	localparam logic [4:0] CMD_SCAN_INIT    = 5'd4;
	localparam logic [4:0] CMD_SCAN_STEP    = 5'd5;
	localparam logic [4:0] CMD_RNG_ALLOC    = 5'd6;
	localparam logic [4:0] CMD_RNG_FREE     = 5'd7;
	localparam logic [4:0] CMD_RNG_FIT      = 5'd8;
	localparam logic [4:0] CMD_RNG_EXT      = 5'd9;
	localparam logic [4:0] CMD_RNG_WR       = 5'd10;
	localparam logic [4:0] CMD_FIT_STEP     = 5'd11;
	localparam logic [4:0] CMD_COMMIT_ALLOC = 5'd12;
	localparam logic [4:0] CMD_COMMIT_FREE  = 5'd13;
	localparam logic [4:0] CMD_COMMIT_EXT   = 5'd14;
	localparam logic [4:0] CMD_RES_FAIL     = 5'd15;
	localparam logic [4:0] CMD_RES_KEEP     = 5'd16;
	localparam logic [4:0] CMD_OUT          = 5'd17;

	typedef struct packed {
		logic [4:0] code;
		logic [1:0] fail_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic [1:0] op;
		logic       bad_size;
		logic       len_zero;
		logic       len_ge_need;
		logic       fit_oob;
		logic       scan_found;
		logic       scan_last;
		logic       range_last;
		logic       fit_busy;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ rtl/bca_ifs.sv @@
// bca_ifs: request and response channel interfaces of the chunk allocator
// depends on bca_pkg for field widths
interface bca_req_if;
	import bca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           op;
	logic [BYTES_W-1:0]   request_bytes;
	logic [CHUNK_AW-1:0]  handle_chunk;
	modport source (output valid, op, request_bytes, handle_chunk, input ready);
	modport sink (input valid, op, request_bytes, handle_chunk, output ready);
endinterface

interface bca_rsp_if;
	import bca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [CHUNK_AW-1:0]  result_chunk;
	logic [COUNT_W-1:0]   result_count;
	logic                 moved;
	logic [COUNT_W-1:0]   allocated_total;
	modport source (output valid, status, result_chunk, result_count, moved,
		allocated_total, input ready);
	modport sink (input valid, status, result_chunk, result_count, moved,
		allocated_total, output ready);
endinterface

@@ rtl/bca_dp.sv @@
// bca_dp: datapath of the allocator, busy bitmap and run length memories,
// word scan logic, counters and output register; depends on bca_pkg
module bca_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bca_pkg::ctl_cmd_t             cmd,
	output bca_pkg::dp_stat_t             stat,
	input  logic                          cfg_wr_en,
	input  logic [bca_pkg::COUNT_W-1:0]   cfg_wr_data,
	input  logic [1:0]                    in_op,
	input  logic [bca_pkg::BYTES_W-1:0]   in_bytes,
	input  logic [bca_pkg::CHUNK_AW-1:0]  in_handle,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    out_status,
	output logic [bca_pkg::CHUNK_AW-1:0]  out_chunk,
	output logic [bca_pkg::COUNT_W-1:0]   out_count,
	output logic                          out_moved,
	output logic [bca_pkg::COUNT_W-1:0]   out_total
);
	import bca_pkg::*;

	logic [WORD_BITS-1:0] busy_mem [NUM_WORDS];
	logic [WORD_BITS-1:0] busy_rd_q;
	logic [COUNT_W-1:0]   rl_mem [NUM_CHUNKS];
	logic [COUNT_W-1:0]   rl_rd_q;

	logic [1:0]          op_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [CHUNK_AW-1:0] h_q;
	logic [NEED_W-1:0]   need_q;
	logic [COUNT_W-1:0]  len_q;
	logic [COUNT_W-1:0]  active_q;
	logic [COUNT_W-1:0]  busy_count_q;
	logic [WORD_AW-1:0]  word_q;
	logic [RUN_W-1:0]    run_q;
	logic [CHUNK_AW-1:0] first_q;
	logic [COUNT_W-1:0]  lo_q;
	logic [COUNT_W-1:0]  hi_q;
	logic                set_q;
	logic [CHUNK_AW-1:0] clr_q;

	logic [1:0]          res_status_q;
	logic [CHUNK_AW-1:0] res_chunk_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                res_moved_q;
	logic                out_valid_q;

	logic [COUNT_W-1:0]   lim;
	logic [BYTES_W-1:0]   lim_bytes;
	logic [WORD_BITS-1:0] rng_mask;
	logic [WORD_BITS-1:0] free_w;
	logic [WORD_BITS-1:0] hit;
	logic                 found;
	logic [WORD_SHIFT-1:0] hit_j;
	logic [RUN_W-1:0]     run_next;
	logic [CHUNK_AW-1:0]  first_calc;
	logic [COUNT_W-1:0]   lo_n;
	logic [COUNT_W-1:0]   hi_n;
	logic [CHUNK_AW-1:0]  idx;
	logic [CHUNK_AW-1:0]  end_idx;
	logic                 rl_we;
	logic [CHUNK_AW-1:0]  rl_waddr;
	logic [COUNT_W-1:0]   rl_wdata;
	logic                 bm_we;
	logic [WORD_BITS-1:0] bm_wdata;
	logic [WORD_AW-1:0]   bm_waddr;

	assign lim = (active_q > COUNT_W'(NUM_CHUNKS)) ? COUNT_W'(NUM_CHUNKS) : active_q;
	assign lim_bytes = BYTES_W'(lim) << CHUNK_SHIFT;

	// per-bit range and heap-end masks of the current word
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			idx = {word_q, WORD_SHIFT'(b)};
			rng_mask[b] = ({1'b0, idx} >= lo_q) && ({1'b0, idx} < hi_q);
			free_w[b] = !busy_rd_q[b] && ({1'b0, idx} < lim);
		end
	end

	// run ending at each bit, then first bit whose run reaches need
	always_comb begin
		logic          has;
		logic [WORD_SHIFT-1:0] lb;
		logic [RUN_W-1:0] run_j;
		run_next = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			has = 1'b0;
			lb = '0;
			for (int k = 0; k <= j; k++) begin
				if (!free_w[k]) begin
					has = 1'b1;
					lb = WORD_SHIFT'(k);
				end
			end
			run_j = has ? (RUN_W'(j) - RUN_W'(lb)) : (run_q + RUN_W'(j + 1));
			hit[j] = run_j >= RUN_W'(need_q);
			if (j == WORD_BITS - 1) begin
				run_next = run_j;
			end
		end
	end

	always_comb begin
		found = 1'b0;
		hit_j = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit[j]) begin
				found = 1'b1;
				hit_j = WORD_SHIFT'(j);
			end
		end
		end_idx = {word_q, hit_j};
		first_calc = CHUNK_AW'(RUN_W'(end_idx) + RUN_W'(1) - RUN_W'(need_q));
	end

	// range bounds for the range commands
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		unique case (cmd.code)
			CMD_RNG_ALLOC: begin
				lo_n = COUNT_W'(first_q);
				hi_n = COUNT_W'(first_q) + need_q[COUNT_W-1:0];
			end
			CMD_RNG_FREE: begin
				lo_n = COUNT_W'(h_q);
				hi_n = COUNT_W'(h_q) + len_q;
			end
			CMD_RNG_FIT, CMD_RNG_EXT: begin
				lo_n = COUNT_W'(h_q) + len_q;
				hi_n = COUNT_W'(h_q) + need_q[COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.clear_done  = clr_q == CHUNK_AW'(NUM_CHUNKS - 1);
		stat.op          = op_q;
		stat.bad_size    = (bytes_q == '0) || (bytes_q > lim_bytes);
		stat.len_zero    = len_q == '0;
		stat.len_ge_need = NEED_W'(len_q) >= need_q;
		stat.fit_oob     = (RUN_W'(h_q) + RUN_W'(need_q)) > RUN_W'(lim);
		stat.scan_found  = found;
		stat.scan_last   = word_q == WORD_AW'((lim - COUNT_W'(1)) >> WORD_SHIFT);
		stat.range_last  = word_q == WORD_AW'((hi_q - COUNT_W'(1)) >> WORD_SHIFT);
		stat.fit_busy    = |(busy_rd_q & rng_mask);
		stat.out_free    = !out_valid_q || out_ready;
	end

	// memory write ports
	always_comb begin
		rl_we = 1'b0;
		rl_waddr = h_q;
		rl_wdata = '0;
		bm_we = 1'b0;
		bm_waddr = word_q;
		bm_wdata = set_q ? (busy_rd_q | rng_mask) : (busy_rd_q & ~rng_mask);
		unique case (cmd.code)
			CMD_CLEAR: begin
				rl_we = 1'b1;
				rl_waddr = clr_q;
				bm_we = clr_q < CHUNK_AW'(NUM_WORDS);
				bm_waddr = clr_q[WORD_AW-1:0];
				bm_wdata = '0;
			end
			CMD_RNG_WR: bm_we = 1'b1;
			CMD_COMMIT_ALLOC: begin
				rl_we = 1'b1;
				rl_waddr = first_q;
				rl_wdata = need_q[COUNT_W-1:0];
			end
			CMD_COMMIT_FREE: rl_we = 1'b1;
			CMD_COMMIT_EXT: begin
				rl_we = 1'b1;
				rl_wdata = need_q[COUNT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			busy_mem[bm_waddr] <= bm_wdata;
		end
		busy_rd_q <= busy_mem[word_q];
	end

	always_ff @(posedge clk) begin
		if (rl_we) begin
			rl_mem[rl_waddr] <= rl_wdata;
		end
		rl_rd_q <= rl_mem[h_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= COUNT_W'(NUM_CHUNKS);
			busy_count_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (cmd.code == CMD_CLEAR) begin
				clr_q <= clr_q + CHUNK_AW'(1);
			end
			unique case (cmd.code)
				CMD_COMMIT_ALLOC: busy_count_q <= busy_count_q + need_q[COUNT_W-1:0];
				CMD_COMMIT_FREE:  busy_count_q <= busy_count_q - len_q;
				CMD_COMMIT_EXT:   busy_count_q <= busy_count_q + need_q[COUNT_W-1:0] - len_q;
				default: begin
				end
			endcase
			if (cmd.code == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.code)
			CMD_LOAD: begin
				op_q <= in_op;
				bytes_q <= in_bytes;
				h_q <= in_handle;
				need_q <= NEED_W'((22'(in_bytes) + 22'(HEADER_BYTES + CHUNK_BYTES - 1))
					>> CHUNK_SHIFT);
			end
			CMD_LEN: len_q <= rl_rd_q;
			CMD_SCAN_INIT: begin
				word_q <= '0;
				run_q <= '0;
			end
			CMD_SCAN_STEP: begin
				if (found) begin
					first_q <= first_calc;
				end else begin
					run_q <= run_next;
					word_q <= word_q + WORD_AW'(1);
				end
			end
			CMD_RNG_ALLOC, CMD_RNG_FREE, CMD_RNG_FIT, CMD_RNG_EXT: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				word_q <= lo_n[CHUNK_AW-1:WORD_SHIFT];
				set_q <= cmd.code != CMD_RNG_FREE;
			end
			CMD_RNG_WR, CMD_FIT_STEP: word_q <= word_q + WORD_AW'(1);
			CMD_COMMIT_ALLOC: begin
				res_status_q <= ST_OK;
				res_chunk_q <= first_q;
				res_count_q <= need_q[COUNT_W-1:0];
				res_moved_q <= 1'b0;
			end
			CMD_COMMIT_FREE: begin
				if (op_q == OP_RESIZE) begin
					res_moved_q <= 1'b1;
				end else begin
					res_status_q <= ST_OK;
					res_chunk_q <= h_q;
					res_count_q <= '0;
					res_moved_q <= 1'b0;
				end
			end
			CMD_COMMIT_EXT: begin
				res_status_q <= ST_OK;
				res_chunk_q <= h_q;
				res_count_q <= need_q[COUNT_W-1:0];
				res_moved_q <= 1'b0;
			end
			CMD_RES_FAIL: begin
				res_status_q <= cmd.fail_status;
				res_chunk_q <= '0;
				res_count_q <= '0;
				res_moved_q <= 1'b0;
			end
			CMD_RES_KEEP: begin
				res_status_q <= ST_OK;
				res_chunk_q <= h_q;
				res_count_q <= len_q;
				res_moved_q <= 1'b0;
			end
			CMD_OUT: begin
				out_status <= res_status_q;
				out_chunk <= res_chunk_q;
				out_count <= res_count_q;
				out_moved <= res_moved_q;
				out_total <= busy_count_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/bca_ctrl.sv @@
// bca_ctrl: request sequencer of the allocator, issues datapath commands
// depends on bca_pkg
module bca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bca_pkg::dp_stat_t stat,
	output bca_pkg::ctl_cmd_t cmd
);
	import bca_pkg::*;

	localparam logic [3:0] S_CLEAR       = 4'd0;
	localparam logic [3:0] S_IDLE        = 4'd1;
	localparam logic [3:0] S_RLRD        = 4'd2;
	localparam logic [3:0] S_LEN         = 4'd3;
	localparam logic [3:0] S_DECIDE      = 4'd4;
	localparam logic [3:0] S_SCAN_RD     = 4'd5;
	localparam logic [3:0] S_SCAN_EV     = 4'd6;
	localparam logic [3:0] S_ALLOC_SETUP = 4'd7;
	localparam logic [3:0] S_RNG_RD      = 4'd8;
	localparam logic [3:0] S_RNG_WR      = 4'd9;
	localparam logic [3:0] S_COMMIT      = 4'd10;
	localparam logic [3:0] S_FREE_SETUP  = 4'd11;
	localparam logic [3:0] S_FIT_RD      = 4'd12;
	localparam logic [3:0] S_FIT_EV      = 4'd13;
	localparam logic [3:0] S_FINISH      = 4'd14;

	localparam logic [1:0] K_ALLOC = 2'd0;
	localparam logic [1:0] K_FREE  = 2'd1;
	localparam logic [1:0] K_EXT   = 2'd2;

	logic [3:0] state_q, state_n;
	logic [1:0] kind_q, kind_n;
	logic       move_q, move_n;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_n = state_q;
		kind_n = kind_q;
		move_n = move_q;
		cmd.code = CMD_NOP;
		cmd.fail_status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.code = CMD_CLEAR;
				if (stat.clear_done) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_LOAD;
					state_n = S_RLRD;
				end
			end
			S_RLRD: state_n = S_LEN;
			S_LEN: begin
				cmd.code = CMD_LEN;
				state_n = S_DECIDE;
			end
			S_DECIDE: begin
				state_n = S_FINISH;
				cmd.code = CMD_RES_FAIL;
				unique case (stat.op)
					OP_ALLOC: begin
						if (stat.bad_size) begin
							cmd.fail_status = ST_BAD_SIZE;
						end else begin
							cmd.code = CMD_SCAN_INIT;
							move_n = 1'b0;
							state_n = S_SCAN_RD;
						end
					end
					OP_FREE: begin
						if (stat.len_zero) begin
							cmd.fail_status = ST_BAD_HANDLE;
						end else begin
							cmd.code = CMD_RNG_FREE;
							kind_n = K_FREE;
							state_n = S_RNG_RD;
						end
					end
					OP_RESIZE: begin
						priority if (stat.len_zero) begin
							cmd.fail_status = ST_BAD_HANDLE;
						end else if (stat.len_ge_need) begin
							cmd.code = CMD_RES_KEEP;
						end else if (!stat.fit_oob) begin
							cmd.code = CMD_RNG_FIT;
							state_n = S_FIT_RD;
						end else if (stat.bad_size) begin
							cmd.fail_status = ST_BAD_SIZE;
						end else begin
							cmd.code = CMD_SCAN_INIT;
							move_n = 1'b1;
							state_n = S_SCAN_RD;
						end
					end
					default: cmd.fail_status = ST_BAD_SIZE;
				endcase
			end
			S_SCAN_RD: state_n = S_SCAN_EV;
			S_SCAN_EV: begin
				priority if (stat.scan_found) begin
					cmd.code = CMD_SCAN_STEP;
					state_n = S_ALLOC_SETUP;
				end else if (stat.scan_last) begin
					cmd.code = CMD_RES_FAIL;
					cmd.fail_status = ST_NO_SPACE;
					state_n = S_FINISH;
				end else begin
					cmd.code = CMD_SCAN_STEP;
					state_n = S_SCAN_RD;
				end
			end
			S_ALLOC_SETUP: begin
				cmd.code = CMD_RNG_ALLOC;
				kind_n = K_ALLOC;
				state_n = S_RNG_RD;
			end
			S_RNG_RD: state_n = S_RNG_WR;
			S_RNG_WR: begin
				cmd.code = CMD_RNG_WR;
				state_n = stat.range_last ? S_COMMIT : S_RNG_RD;
			end
			S_COMMIT: begin
				state_n = S_FINISH;
				unique case (kind_q)
					K_ALLOC: begin
						cmd.code = CMD_COMMIT_ALLOC;
						if (move_q) begin
							state_n = S_FREE_SETUP;
						end
					end
					K_FREE: cmd.code = CMD_COMMIT_FREE;
					default: cmd.code = CMD_COMMIT_EXT;
				endcase
			end
			S_FREE_SETUP: begin
				cmd.code = CMD_RNG_FREE;
				kind_n = K_FREE;
				state_n = S_RNG_RD;
			end
			S_FIT_RD: state_n = S_FIT_EV;
			S_FIT_EV: begin
				priority if (stat.fit_busy) begin
					if (stat.bad_size) begin
						cmd.code = CMD_RES_FAIL;
						cmd.fail_status = ST_BAD_SIZE;
						state_n = S_FINISH;
					end else begin
						cmd.code = CMD_SCAN_INIT;
						move_n = 1'b1;
						state_n = S_SCAN_RD;
					end
				end else if (stat.range_last) begin
					cmd.code = CMD_RNG_EXT;
					kind_n = K_EXT;
					state_n = S_RNG_RD;
				end else begin
					cmd.code = CMD_FIT_STEP;
					state_n = S_FIT_RD;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.code = CMD_OUT;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q <= K_ALLOC;
			move_q <= 1'b0;
		end else begin
			state_q <= state_n;
			kind_q <= kind_n;
			move_q <= move_n;
		end
	end

endmodule

@@ rtl/bitmap_chunk_allocator_core.sv @@
// bitmap_chunk_allocator_core: one request at a time; an allocate scans the busy bitmap
// one 64-chunk word at a time (up to 128 words), then marks the run word by word;
// free clears its run word by word; in-place resize checks, then marks, each added word
// after reset a clearing pass zeroes both memories, requests wait for it
// the result sits in an output register, so the next request is taken while it waits
// depends on bca_pkg, bca_ifs, bca_ctrl and bca_dp
module bitmap_chunk_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	bca_req_if.sink                     req,
	bca_rsp_if.source                   rsp,
	input  logic                        cfg_wr_en,
	input  logic [bca_pkg::COUNT_W-1:0] cfg_wr_data
);
	import bca_pkg::*;

	// command and status between sequencer and datapath
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: clearing pass, request decode, scan and range loops
	bca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: bitmap and run length memories, counters, result beat register
	bca_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (req.op),
		.in_bytes    (req.request_bytes),
		.in_handle   (req.handle_chunk),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_status  (rsp.status),
		.out_chunk   (rsp.result_chunk),
		.out_count   (rsp.result_count),
		.out_moved   (rsp.moved),
		.out_total   (rsp.allocated_total)
	);

endmodule

@@ tb/bitmap_chunk_allocator_core_test.sv @@
// bitmap_chunk_allocator_core_test: self-checking bench for the chunk allocator core
// drives allocate, free and resize beats and checks each response against a heap predictor
// depends on bca_pkg, bca_ifs and the bitmap_chunk_allocator_core rtl
module bitmap_chunk_allocator_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bca_pkg::*;

	localparam int WATCHDOG_CYCLES = 60000;
	localparam int DRAIN_CYCLES    = 800;

	typedef struct packed {
		logic [1:0]          status;
		logic [CHUNK_AW-1:0] chunk;
		logic [COUNT_W-1:0]  count;
		logic                moved;
		logic [COUNT_W-1:0]  total;
	} alloc_result_t;

	typedef struct {
		logic [1:0]          op;
		logic [BYTES_W-1:0]  bytes;
		logic [CHUNK_AW-1:0] handle;
		bit                  typed;
		alloc_result_t       want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;

	bca_req_if req ();
	bca_rsp_if rsp ();

	bitmap_chunk_allocator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req.sink),
		.rsp         (rsp.source),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---- heap predictor state ----
	bit          busy_bits [NUM_CHUNKS];
	int unsigned run_len [NUM_CHUNKS];
	int unsigned busy_total;
	int unsigned heap_active;
	int          live_runs [$];          // handles of runs the predictor holds

	alloc_result_t pending_results [$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          no_idle = 1'b0;

	// what the current request beat carries when its result is typed in
	bit            beat_typed = 1'b0;
	alloc_result_t beat_want;

	function automatic int unsigned heap_limit();
		return (heap_active > NUM_CHUNKS) ? NUM_CHUNKS : heap_active;
	endfunction

	function automatic int unsigned chunks_needed(int unsigned nbytes);
		return (nbytes + HEADER_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
	endfunction

	function automatic void drop_live(int unsigned h);
		foreach (live_runs[k])
			if (live_runs[k] == h) begin
				live_runs.delete(k);
				return;
			end
	endfunction

	// first fit over the bitmap; returns a status code
	function automatic logic [1:0] heap_take(int unsigned nbytes, output int unsigned start,
			output int unsigned cnt);
		int unsigned lim, need, first, run;
		lim = heap_limit();
		first = 0;
		run = 0;
		start = 0;
		cnt = 0;
		if (nbytes == 0 || nbytes > lim * CHUNK_BYTES)
			return ST_BAD_SIZE;
		need = chunks_needed(nbytes);
		for (int unsigned i = 0; i < lim; i++) begin
			if (!busy_bits[i]) begin
				if (run == 0)
					first = i;
				run++;
				if (run == need)
					break;
			end else begin
				run = 0;
			end
		end
		if (run != need || need == 0)
			return ST_NO_SPACE;
		for (int unsigned i = first; i < first + need; i++)
			busy_bits[i] = 1'b1;
		run_len[first] = need;
		busy_total += need;
		start = first;
		cnt = need;
		live_runs.push_back(int'(first));
		return ST_OK;
	endfunction

	function automatic void heap_release(int unsigned h);
		int unsigned len;
		len = run_len[h];
		for (int unsigned i = h; i < h + len && i < NUM_CHUNKS; i++)
			busy_bits[i] = 1'b0;
		busy_total -= len;
		run_len[h] = 0;
		drop_live(h);
	endfunction

	// one request in, the one response it must produce out
	function automatic alloc_result_t heap_step(logic [1:0] op, int unsigned nbytes,
			int unsigned h);
		alloc_result_t r;
		int unsigned start, cnt, len, need;
		bit fits;
		r = '0;
		start = 0;
		cnt = 0;
		if (op == OP_ALLOC) begin
			r.status = heap_take(nbytes, start, cnt);
			r.chunk = CHUNK_AW'(start);
			r.count = COUNT_W'(cnt);
		end else if (op == OP_FREE || op == OP_RESIZE) begin
			if (run_len[h] == 0) begin
				r.status = ST_BAD_HANDLE;
			end else if (op == OP_FREE) begin
				heap_release(h);
				r.chunk = CHUNK_AW'(h);
			end else begin
				len = run_len[h];
				need = chunks_needed(nbytes);
				if (len >= need) begin
					r.chunk = CHUNK_AW'(h);
					r.count = COUNT_W'(len);
				end else begin
					fits = (h + need <= heap_limit());
					for (int unsigned i = h + len; fits && i < h + need; i++)
						if (busy_bits[i])
							fits = 1'b0;
					if (fits) begin
						// grow in place
						for (int unsigned i = h + len; i < h + need; i++)
							busy_bits[i] = 1'b1;
						busy_total += need - len;
						run_len[h] = need;
						r.chunk = CHUNK_AW'(h);
						r.count = COUNT_W'(need);
					end else begin
						r.status = heap_take(nbytes, start, cnt);
						if (r.status == ST_OK) begin
							heap_release(h);
							r.chunk = CHUNK_AW'(start);
							r.count = COUNT_W'(cnt);
							r.moved = 1'b1;
						end
					end
				end
			end
		end else begin
			r.status = ST_BAD_SIZE;
		end
		if (r.status != ST_OK) begin
			r.chunk = '0;
			r.count = '0;
			r.moved = 1'b0;
		end
		r.total = COUNT_W'(busy_total);
		return r;
	endfunction

	// ---- sampling at the rising edge: predict on request beats, check response beats ----
	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				want = heap_step(req.op, 32'(req.request_bytes), 32'(req.handle_chunk));
				// typed rows still run the predictor so its heap stays in step
				if (beat_typed)
					want = beat_want;
				pending_results.push_back(want);
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.result_chunk, rsp.result_count, rsp.moved,
					rsp.allocated_total};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response beat %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("response mismatch: expected %p, got %p", want, got);
					end
				end
			end
			// watchdog: cycles with no beat on either side
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 55)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 80));
	endfunction

	// response side back-pressure, changed on falling edges
	always @(negedge clk) begin
		int g;
		if (!arst_n) begin
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = 1'b1;
			g = gap_len();
			if (g > 0 && !no_idle) begin
				@(negedge clk);
				rsp.ready = 1'b0;
				repeat (g) @(negedge clk);
				rsp.ready = 1'b1;
			end
		end
	end

	// one request beat; called at a falling edge, returns at a falling edge
	task automatic send_request(logic [1:0] op, logic [BYTES_W-1:0] nbytes,
			logic [CHUNK_AW-1:0] h, bit typed, alloc_result_t want);
		repeat (gap_len()) @(negedge clk);
		req.op = op;
		req.request_bytes = nbytes;
		req.handle_chunk = h;
		beat_typed = typed;
		beat_want = want;
		req.valid = 1'b1;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
		beat_typed = 1'b0;
	endtask

	// register write only once the core has gone quiet
	task automatic set_active_chunks(logic [COUNT_W-1:0] value);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_data = value;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		heap_active = 32'(value);
	endtask

	function automatic logic [BYTES_W-1:0] pick_size();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 70)
			return BYTES_W'($urandom_range(1, 600));
		if (r < 95)
			return BYTES_W'($urandom_range(1, 8000));
		if (r < 99)
			return BYTES_W'($urandom_range(1, 200000));
		return BYTES_W'($urandom_range(1, 1048576));
	endfunction

	// well-formed traffic on live handles, with some noise mixed in
	task automatic random_phase(int n_items, int pause_at);
		int r;
		logic [CHUNK_AW-1:0] h;
		for (int k = 0; k < n_items; k++) begin
			if (k == pause_at)
				while (pending_results.size() != 0)
					@(negedge clk);
			// every so often run a burst with no idling on either side
			if (k % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			r = int'($urandom_range(0, 99));
			h = (live_runs.size() != 0) ?
				CHUNK_AW'(live_runs[$urandom_range(0, live_runs.size() - 1)]) : '0;
			if (r < 45 || (r < 88 && live_runs.size() == 0))
				send_request(OP_ALLOC, pick_size(), CHUNK_AW'($urandom), 1'b0, '0);
			else if (r < 70)
				send_request(OP_FREE, BYTES_W'($urandom), h, 1'b0, '0);
			else if (r < 88)
				send_request(OP_RESIZE, pick_size(), h, 1'b0, '0);
			else
				case ($urandom_range(0, 4))
					0: send_request(OP_BAD, BYTES_W'($urandom), CHUNK_AW'($urandom), 1'b0,
						'0);
					1: send_request(OP_ALLOC, '0, CHUNK_AW'($urandom), 1'b0, '0);
					2: send_request(OP_ALLOC, BYTES_W'($urandom), CHUNK_AW'($urandom), 1'b0,
						'0);
					3: send_request(OP_FREE, BYTES_W'($urandom), CHUNK_AW'($urandom), 1'b0,
						'0);
					default: send_request(OP_RESIZE, BYTES_W'($urandom), CHUNK_AW'($urandom),
						1'b0, '0);
				endcase
		end
		no_idle = 1'b0;
	endtask

	// directed rows; typed results only where they follow at a glance
	stim_row_t directed [$];

	function automatic stim_row_t row(logic [1:0] op, int unsigned nbytes, int unsigned h,
			bit typed = 1'b0, alloc_result_t want = '0);
		stim_row_t s;
		s.op = op;
		s.bytes = BYTES_W'(nbytes);
		s.handle = CHUNK_AW'(h);
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	initial begin
		int unsigned tail;
		req.valid = 1'b0;
		req.op = OP_ALLOC;
		req.request_bytes = '0;
		req.handle_chunk = '0;
		busy_total = 0;
		heap_active = NUM_CHUNKS;
		foreach (run_len[i]) begin
			run_len[i] = 0;
			busy_bits[i] = 1'b0;
		end

		// first allocation after reset lands on chunk 0
		directed.push_back(row(OP_ALLOC, 1, 0, 1'b1, '{ST_OK, 13'd0, 14'd1, 1'b0, 14'd1}));
		// zero bytes, top of the field, unknown op
		directed.push_back(row(OP_ALLOC, 0, 0, 1'b1,
			'{ST_BAD_SIZE, 13'd0, 14'd0, 1'b0, 14'd1}));
		directed.push_back(row(OP_ALLOC, 2097151, 8191, 1'b1,
			'{ST_BAD_SIZE, 13'd0, 14'd0, 1'b0, 14'd1}));
		directed.push_back(row(OP_BAD, 2097151, 8191, 1'b1,
			'{ST_BAD_SIZE, 13'd0, 14'd0, 1'b0, 14'd1}));
		// largest legal size rounds past the heap, a whole-heap run finds chunk 0 taken: no space
		directed.push_back(row(OP_ALLOC, 1048576, 0, 1'b1,
			'{ST_NO_SPACE, 13'd0, 14'd0, 1'b0, 14'd1}));
		directed.push_back(row(OP_ALLOC, 1048560, 0, 1'b1,
			'{ST_NO_SPACE, 13'd0, 14'd0, 1'b0, 14'd1}));
		// handles with no run
		directed.push_back(row(OP_FREE, 0, 8191, 1'b1,
			'{ST_BAD_HANDLE, 13'd0, 14'd0, 1'b0, 14'd1}));
		directed.push_back(row(OP_RESIZE, 50, 1, 1'b1,
			'{ST_BAD_HANDLE, 13'd0, 14'd0, 1'b0, 14'd1}));
		// resize already long enough, grow in place, then forced move
		directed.push_back(row(OP_RESIZE, 0, 0));
		directed.push_back(row(OP_RESIZE, 200, 0));
		directed.push_back(row(OP_ALLOC, 100, 0));
		directed.push_back(row(OP_RESIZE, 300, 0));
		// move that cannot be satisfied keeps the old run
		directed.push_back(row(OP_RESIZE, 1048560, 3));
		directed.push_back(row(OP_RESIZE, 2097151, 3));
		directed.push_back(row(OP_FREE, 0, 2));
		directed.push_back(row(OP_FREE, 0, 3));
		directed.push_back(row(OP_FREE, 0, 3));
		// whole heap in one run, then free it
		directed.push_back(row(OP_ALLOC, 1048560, 0));
		directed.push_back(row(OP_ALLOC, 1, 0));
		directed.push_back(row(OP_FREE, 0, 0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_request(directed[i].op, directed[i].bytes, directed[i].handle,
				directed[i].typed, directed[i].want);

		// random part across several heap sizes, extremes included
		random_phase(600, 300);
		set_active_chunks(14'd1);
		random_phase(150, -1);
		set_active_chunks(14'd100);
		random_phase(400, -1);
		set_active_chunks(14'd16383);
		random_phase(400, -1);
		set_active_chunks(14'd3000);
		random_phase(380, -1);

		// drain, then let the core settle
		tail = 0;
		while (pending_results.size() != 0 && tail < WATCHDOG_CYCLES) begin
			@(negedge clk);
			tail++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
